FILE: src/wildcard_pattern_matcher_unit_assert.svh
// ----------------------------------------------------------------------------
// wildcard pattern matcher assertion macros
// concurrent checks clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef WILDCARD_PATTERN_MATCHER_UNIT_ASSERT_SVH
`define WILDCARD_PATTERN_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication
`define WPM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wpm check failed");

// next-cycle implication
`define WPM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wpm check failed");

`endif

FILE: src/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg
// shared types, widths and character codes of the wildcard pattern matcher
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

	localparam int MODE_W = 2;
	localparam int SYM_W  = 8;
	localparam int IDX_W  = 6;
	localparam int LEN_W  = 7;

	typedef enum logic [MODE_W-1:0] {
		MODE_PATTERN = 2'd0,
		MODE_TEXT    = 2'd1,
		MODE_END     = 2'd2
	} mode_t;

	localparam logic [SYM_W-1:0] CH_QMARK = 8'h3F;
	localparam logic [SYM_W-1:0] CH_LOW_A = 8'h61;
	localparam logic [SYM_W-1:0] CH_LOW_Z = 8'h7A;

	typedef struct packed {
		logic             text;
		logic             restart;
		logic             wr;
		logic [SYM_W-1:0] symbol;
	} cell_cmd_t;

	function automatic logic is_star(input logic [SYM_W-1:0] b);
		logic letter;
		letter = (b >= CH_LOW_A) && (b <= CH_LOW_Z);
		return !letter && (b != CH_QMARK);
	endfunction

endpackage

`default_nettype wire

FILE: src/wpm_in_if.sv
// ----------------------------------------------------------------------------
// wpm_in_if
// input beat channel: pattern writes, text bytes and end of text
// ----------------------------------------------------------------------------
`default_nettype none

interface wpm_in_if;
	logic                      valid;
	logic                      ready;
	logic [wpm_pkg::MODE_W-1:0] mode;
	logic [wpm_pkg::SYM_W-1:0]  symbol;
	logic [wpm_pkg::IDX_W-1:0]  pattern_index;

	modport source (output valid, mode, symbol, pattern_index, input ready);
	modport sink   (input valid, mode, symbol, pattern_index, output ready);
endinterface

`default_nettype wire

FILE: src/wpm_out_if.sv
// ----------------------------------------------------------------------------
// wpm_out_if
// result beat channel: match flag at end of text
// ----------------------------------------------------------------------------
`default_nettype none

interface wpm_out_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, matched, input ready);
	modport sink   (input valid, matched, output ready);
endinterface

`default_nettype wire

FILE: src/wpm_cfg_if.sv
// ----------------------------------------------------------------------------
// wpm_cfg_if
// configuration write channel for the pattern length register
// ----------------------------------------------------------------------------
`default_nettype none

interface wpm_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [wpm_pkg::LEN_W-1:0] pattern_length;

	modport source (output valid, pattern_length, input ready);
	modport sink   (input valid, pattern_length, output ready);
endinterface

`default_nettype wire

FILE: src/wpm_cell.sv
// ----------------------------------------------------------------------------
// wpm_cell
// one pattern position: stored byte, active bit, advance to the next cell
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_cell #(
	parameter bit RESET_ACTIVE = 1'b0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire wpm_pkg::cell_cmd_t cmd,
	input  wire                 wr_sel,
	input  wire                 closed,
	input  wire                 in_len,
	input  wire                 adv_in,
	output logic                adv_out,
	output logic                star,
	output logic                active
);

	logic [wpm_pkg::SYM_W-1:0] byte_q;
	logic                      active_q;
	logic                      live;
	logic                      keep;

	assign star    = wpm_pkg::is_star(byte_q);
	assign live    = closed && in_len;
	assign keep    = live && star;
	assign adv_out = live && !star && ((byte_q == wpm_pkg::CH_QMARK) || (byte_q == cmd.symbol));
	assign active  = active_q;

	always_ff @(posedge clk) begin
		if (cmd.wr && wr_sel) begin
			byte_q <= cmd.symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= RESET_ACTIVE;
		end else if (cmd.restart) begin
			active_q <= RESET_ACTIVE;
		end else if (cmd.text) begin
			active_q <= keep || adv_in;
		end
	end

endmodule

`default_nettype wire

FILE: src/wpm_closure.sv
// ----------------------------------------------------------------------------
// wpm_closure
// star closure over the active set as one carry chain
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_closure #(
	parameter int MAX_PATTERN = 64
) (
	input  wire  [MAX_PATTERN:0]   active,
	input  wire  [MAX_PATTERN-1:0] star,
	input  wire  [MAX_PATTERN-1:0] in_len,
	output logic [MAX_PATTERN:0]   closed
);

	logic [MAX_PATTERN:0] prop;
	logic [MAX_PATTERN:0] gen;
	logic [MAX_PATTERN:0] sum;
	logic [MAX_PATTERN:0] carry;

	// carry into position i+1 = star(i) & in_len(i) & (active(i) | carry(i))
	assign prop   = {1'b0, star & in_len};
	assign gen    = active & prop;
	assign sum    = prop + gen;
	assign carry  = sum ^ prop ^ gen;
	assign closed = active | carry;

endmodule

`default_nettype wire

FILE: src/wildcard_pattern_matcher_unit.sv
// an end-of-text result is registered in the output register, or in skid while that waits
// throughput: one beat per cycle if skid is empty; the full-row carry chain sets the cycle
// pattern, text and end beats all update the cell row in the cycle they are accepted
// a two-entry output buffer keeps input flowing while one result waits
// reset: active set holds position zero only, length is zero, pattern bytes undefined
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_unit
// streams text bytes through a row of pattern cells and reports a match at end of text
// ----------------------------------------------------------------------------
`default_nettype none

`include "wildcard_pattern_matcher_unit_assert.svh"

module wildcard_pattern_matcher_unit #(
	parameter int MAX_PATTERN = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	wpm_cfg_if.sink     cfg,
	wpm_in_if.sink      item,
	wpm_out_if.source   result
);

	logic [wpm_pkg::LEN_W-1:0] len_q;
	logic                      act_end_q;
	logic                      out_v_q;
	logic                      out_d_q;
	logic                      skid_v_q;
	logic                      skid_d_q;

	logic                      acc;
	logic                      push;
	logic                      push_d;
	logic                      pop;
	wpm_pkg::cell_cmd_t        cmd;

	logic [MAX_PATTERN-1:0]    wr_sel;
	logic [MAX_PATTERN-1:0]    in_len;
	logic [MAX_PATTERN-1:0]    star;
	logic [MAX_PATTERN-1:0]    cell_act;
	logic [MAX_PATTERN:0]      le_mask;
	logic [MAX_PATTERN:0]      at_end;
	logic [MAX_PATTERN:0]      act_vec;
	logic [MAX_PATTERN:0]      closed;
	logic [MAX_PATTERN:0]      adv;

	assign cfg.ready  = 1'b1;
	assign item.ready = !skid_v_q;
	assign acc        = item.valid && item.ready;
	assign pop        = out_v_q && result.ready;

	assign cmd.text    = acc && (item.mode == wpm_pkg::MODE_TEXT);
	assign cmd.restart = acc && (item.mode == wpm_pkg::MODE_END);
	assign cmd.wr      = acc && (item.mode == wpm_pkg::MODE_PATTERN);
	assign cmd.symbol  = item.symbol;

	// write select against the pattern index, position masks against the current length
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_mask
		assign wr_sel[i] = 32'(item.pattern_index) == 32'(i);
		assign in_len[i] = 32'(len_q) > 32'(i);
		assign le_mask[i] = 32'(len_q) >= 32'(i);
		assign at_end[i] = 32'(len_q) == 32'(i);
	end
	assign le_mask[MAX_PATTERN] = 32'(len_q) >= 32'(MAX_PATTERN);
	assign at_end[MAX_PATTERN]  = 32'(len_q) >= 32'(MAX_PATTERN);

	assign act_vec = {act_end_q, cell_act};
	assign adv[0]  = 1'b0;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		wpm_cell #(
			.RESET_ACTIVE(i == 0)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.wr_sel  (wr_sel[i]),
			.closed  (closed[i]),
			.in_len  (in_len[i]),
			.adv_in  (adv[i]),
			.adv_out (adv[i+1]),
			.star    (star[i]),
			.active  (cell_act[i])
		);
	end

	wpm_closure #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_closure (
		.active (act_vec & le_mask),
		.star   (star),
		.in_len (in_len),
		.closed (closed)
	);

	assign push   = cmd.restart;
	assign push_d = |(closed & at_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			act_end_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				len_q <= cfg.pattern_length;
			end
			if (cmd.restart) begin
				act_end_q <= 1'b0;
			end else if (cmd.text) begin
				act_end_q <= adv[MAX_PATTERN];
			end
		end
	end

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			out_d_q <= skid_v_q ? skid_d_q : push_d;
		end else if (push) begin
			skid_d_q <= push_d;
		end
	end

	assign result.valid   = out_v_q;
	assign result.matched = out_d_q;

	`WPM_ASSERT_NOW(a_skid_behind_out, skid_v_q, out_v_q)
	`WPM_ASSERT_NEXT(a_end_gives_result, push, out_v_q)
	`WPM_ASSERT_NEXT(a_end_restarts_set, cmd.restart, act_vec == (MAX_PATTERN+1)'(1))
	`WPM_ASSERT_NEXT(a_text_within_len, cmd.text, (act_vec & ~$past(le_mask)) == '0)

endmodule

`default_nettype wire
